/* hw/rtl/vtpd_pkg.sv */
// Shared constants and types for the vertex transform and perspective divide pipeline.
package vtpd_pkg;

	localparam int FRAC_BITS      = 16;
	localparam int XY_W           = 32;
	localparam int PROD_W         = 2 * XY_W;
	localparam int CFG_IDX_W      = 8;
	localparam int CFG_W          = 64;
	localparam int MAT_REGS       = 8;
	localparam int HW             = 65 - FRAC_BITS;
	localparam int DIV_BITS       = 36;
	localparam int BITS_PER_STAGE = 4;
	localparam int DIV_STAGES     = DIV_BITS / BITS_PER_STAGE;
	localparam int NUM_STAGES     = DIV_STAGES + 4;

	localparam logic [CFG_IDX_W-1:0] MAT_REG_LAST = CFG_IDX_W'(MAT_REGS - 1);

	typedef logic signed [XY_W-1:0] coord_t;
	typedef logic signed [HW-1:0] hcoord_t;

	typedef struct packed {
		logic [HW-1:0]       rem;
		logic [DIV_BITS-1:0] nsh;
		logic [DIV_BITS-1:0] quo;
		logic                ovf;
		logic                neg;
	} lane_t;

	typedef struct packed {
		lane_t [2:0]   lane;
		logic [HW-1:0] den;
		logic          w_zero;
	} div_t;

endpackage

/* hw/rtl/vtpd_mat_mul.sv */
// Two pipeline stages: matrix by vertex products, then shifted row sums.
module vtpd_mat_mul
	import vtpd_pkg::*;
(
	input  logic    clk,
	input  logic    en_s1,
	input  logic    en_s2,
	input  coord_t  pos [3],
	input  coord_t  mat [4][4],
	output hcoord_t h_s2 [4]
);

	logic signed [PROD_W-1:0] prod_s1 [4][3];
	coord_t                   mc3_s1 [4];
	hcoord_t                  acc [4];

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int r = 0; r < 4; r++) begin
				mc3_s1[r] <= mat[r][3];
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= mat[r][c] * pos[c];
				end
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			acc[r] = HW'(mc3_s1[r]);
			for (int c = 0; c < 3; c++) begin
				acc[r] = acc[r] + HW'(prod_s1[r][c] >>> FRAC_BITS);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			h_s2 <= acc;
		end
	end

endmodule

/* hw/rtl/vtpd_div_stage.sv */
// One stage of the three-lane restoring divider, several quotient bits per stage.
module vtpd_div_stage
	import vtpd_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  div_t din,
	output div_t dout_sn
);

	div_t          d;
	logic [HW:0]   r2;
	logic          ge;

	always_comb begin
		d  = din;
		r2 = '0;
		ge = 1'b0;
		for (int l = 0; l < 3; l++) begin
			for (int s = 0; s < BITS_PER_STAGE; s++) begin
				r2 = {d.lane[l].rem, d.lane[l].nsh[DIV_BITS-1]};
				d.lane[l].nsh = {d.lane[l].nsh[DIV_BITS-2:0], 1'b0};
				ge = r2 >= {1'b0, d.den};
				if (ge) begin
					r2 = r2 - {1'b0, d.den};
				end
				d.lane[l].quo = {d.lane[l].quo[DIV_BITS-2:0], ge};
				d.lane[l].rem = r2[HW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout_sn <= d;
		end
	end

endmodule

/* hw/rtl/vertex_transform_perspective_divide_core.sv */
// Top level of the vertex transform and perspective divide pipeline.
//
// Input channel: pos_x, pos_y, pos_z with in_valid; a transaction completes
// on a clock edge with in_valid high and in_stall low. Output channel:
// ndc_x, ndc_y, ndc_z, w_was_zero, clamped with out_valid and out_stall.
// The matrix is loaded through cfg_valid, cfg_ready, cfg_index, cfg_data;
// cfg_ready is always high and indexes beyond seven are dropped. Write the
// matrix only while the pipeline is empty.
// An input transaction passes through one multiply stage, one row-sum stage,
// one divider setup stage, nine divider stages of four quotient bits each and
// one saturation stage. One vertex is accepted per cycle while in_stall is
// low. Reset empties the pipeline and loads the identity matrix. While the
// receiver stalls, results hold at the output and earlier stages keep moving
// until they fill; in_stall rises only when every stage holds a transaction.
module vertex_transform_perspective_divide_core
	import vtpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [31:0]   pos_z,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   ndc_x,
	output logic signed [31:0]   ndc_y,
	output logic signed [31:0]   ndc_z,
	output logic                 w_was_zero,
	output logic                 clamped,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
	localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(1) << (FRAC_BITS + XY_W);
	localparam int SETUP_STG = 2;
	localparam int LAST_STG  = NUM_STAGES - 1;

	logic [CFG_W-1:0] mat_q [MAT_REGS];
	logic [NUM_STAGES-1:0] vld_s;
	logic [NUM_STAGES:0]   en;
	coord_t  pos [3];
	coord_t  mat [4][4];
	hcoord_t h_s2 [4];
	div_t    setup_d;
	div_t    div_s [DIV_STAGES+1];
	logic signed [XY_W-1:0] res_d [3];
	logic    clamp_d;
	logic signed [XY_W-1:0] ndc_s13 [3];
	logic    wz_s13;
	logic    clamp_s13;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= ONE_LO;
			mat_q[1] <= '0;
			mat_q[2] <= ONE_HI;
			mat_q[3] <= '0;
			mat_q[4] <= '0;
			mat_q[5] <= ONE_LO;
			mat_q[6] <= '0;
			mat_q[7] <= ONE_HI;
		end else if (cfg_valid && cfg_ready && cfg_index <= MAT_REG_LAST) begin
			mat_q[cfg_index[2:0]] <= cfg_data;
		end
	end

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				mat[r][c] = coord_t'(mat_q[r * 2 + c / 2][(c % 2) * XY_W +: XY_W]);
			end
		end
	end

	always_comb begin
		en[NUM_STAGES] = !out_stall;
		for (int i = NUM_STAGES - 1; i >= 0; i--) begin
			en[i] = !vld_s[i] || en[i+1];
		end
	end

	assign in_stall  = !en[0];
	assign out_valid = vld_s[LAST_STG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int i = 1; i < NUM_STAGES; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	assign pos[0] = pos_x;
	assign pos[1] = pos_y;
	assign pos[2] = pos_z;

	vtpd_mat_mul u_mat_mul (
		.clk   (clk),
		.en_s1 (en[0]),
		.en_s2 (en[1]),
		.pos   (pos),
		.mat   (mat),
		.h_s2  (h_s2)
	);

	always_comb begin
		logic [HW-1:0] an;
		logic [HW-1:0] ad;
		ad = h_s2[3][HW-1] ? HW'(-h_s2[3]) : HW'(h_s2[3]);
		setup_d.den    = ad;
		setup_d.w_zero = h_s2[3] == '0;
		for (int l = 0; l < 3; l++) begin
			an = h_s2[l][HW-1] ? HW'(-h_s2[l]) : HW'(h_s2[l]);
			setup_d.lane[l].rem = an >> (DIV_BITS - FRAC_BITS);
			setup_d.lane[l].nsh = {an[DIV_BITS-FRAC_BITS-1:0], FRAC_BITS'(0)};
			setup_d.lane[l].quo = '0;
			setup_d.lane[l].ovf = (an >> (DIV_BITS - FRAC_BITS)) >= ad;
			setup_d.lane[l].neg = h_s2[l][HW-1] ^ h_s2[3][HW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[SETUP_STG]) begin
			div_s[0] <= setup_d;
		end
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		vtpd_div_stage u_div_stage (
			.clk     (clk),
			.en      (en[SETUP_STG+1+k]),
			.din     (div_s[k]),
			.dout_sn (div_s[k+1])
		);
	end

	always_comb begin
		logic [DIV_BITS-1:0] limit;
		logic [DIV_BITS-1:0] mag;
		logic                sat;
		clamp_d = 1'b0;
		for (int l = 0; l < 3; l++) begin
			limit = div_s[DIV_STAGES].lane[l].neg ? (DIV_BITS'(1) << (XY_W - 1))
				: ((DIV_BITS'(1) << (XY_W - 1)) - DIV_BITS'(1));
			sat = div_s[DIV_STAGES].lane[l].ovf || (div_s[DIV_STAGES].lane[l].quo > limit);
			mag = sat ? limit : div_s[DIV_STAGES].lane[l].quo;
			res_d[l] = div_s[DIV_STAGES].lane[l].neg ? -mag[XY_W-1:0] : mag[XY_W-1:0];
			clamp_d = clamp_d | sat;
			if (div_s[DIV_STAGES].w_zero) begin
				res_d[l] = '0;
			end
		end
		if (div_s[DIV_STAGES].w_zero) begin
			clamp_d = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en[LAST_STG]) begin
			ndc_s13   <= res_d;
			wz_s13    <= div_s[DIV_STAGES].w_zero;
			clamp_s13 <= clamp_d;
		end
	end

	assign ndc_x      = ndc_s13[0];
	assign ndc_y      = ndc_s13[1];
	assign ndc_z      = ndc_s13[2];
	assign w_was_zero = wz_s13;
	assign clamped    = clamp_s13;

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (&vld_s))
		else $error("Input stalled while a pipeline stage is empty.");

	a_wzero_out: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && w_was_zero) |-> (!clamped && ndc_x == 0 && ndc_y == 0 && ndc_z == 0))
		else $error("Zero w result carries nonzero coordinates or clamp.");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(ndc_x) && $stable(clamped)))
		else $error("Stalled result changed.");

endmodule

/* verif/vertex_transform_perspective_divide_core_test.sv */
// Self-checking testbench for the vertex transform and perspective divide core.
module vertex_transform_perspective_divide_core_test;
	import vtpd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic               wz;
		logic               cl;
	} ndc_t;

	class ndc_scoreboard;
		logic [CFG_W-1:0] mat [MAT_REGS];
		ndc_t             pending [$];
		int               errors;

		function new();
			errors = 0;
			for (int i = 0; i < MAT_REGS; i++) begin
				mat[i] = '0;
			end
			mat[0] = 64'(1) << FRAC_BITS;
			mat[2] = 64'(1) << (32 + FRAC_BITS);
			mat[5] = 64'(1) << FRAC_BITS;
			mat[7] = 64'(1) << (32 + FRAC_BITS);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
			if (idx < MAT_REGS) begin
				mat[idx] = data;
			end
		endfunction

		function logic signed [63:0] entry(int r, int c);
			logic [63:0]        rv;
			logic signed [31:0] e;
			rv = mat[r * 2 + c / 2];
			e = (c % 2 == 1) ? rv[63:32] : rv[31:0];
			return 64'(e);
		endfunction

		function logic [31:0] quotient(logic [63:0] num, logic [63:0] den, inout bit cl);
			bit          neg;
			logic [63:0] an;
			logic [63:0] ad;
			logic [63:0] lim;
			logic [63:0] ip;
			logic [63:0] rem;
			logic [63:0] q;
			neg = num[63] ^ den[63];
			an = num[63] ? -num : num;
			ad = den[63] ? -den : den;
			lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
			ip = an / ad;
			rem = an % ad;
			if (ip > (64'h8000_0000 >> FRAC_BITS)) begin
				q = lim + 1;
			end else begin
				q = ip;
				for (int i = 0; i < FRAC_BITS; i++) begin
					rem = rem << 1;
					q = q << 1;
					if (rem >= ad) begin
						rem = rem - ad;
						q = q | 64'd1;
					end
				end
			end
			if (q > lim) begin
				q = lim;
				cl = 1'b1;
			end
			return neg ? 32'(-q) : q[31:0];
		endfunction

		function void note_vertex(logic signed [31:0] px, logic signed [31:0] py,
				logic signed [31:0] pz);
			logic signed [63:0] v [3];
			logic [63:0]        h [4];
			logic signed [63:0] prod;
			bit                 cl;
			ndc_t               e;
			v[0] = 64'(px);
			v[1] = 64'(py);
			v[2] = 64'(pz);
			cl = 1'b0;
			for (int r = 0; r < 4; r++) begin
				h[r] = entry(r, 3);
				for (int c = 0; c < 3; c++) begin
					prod = entry(r, c) * v[c];
					h[r] = h[r] + 64'(prod >>> FRAC_BITS);
				end
			end
			if (h[3] == 0) begin
				e.x = 0;
				e.y = 0;
				e.z = 0;
				e.wz = 1'b1;
				e.cl = 1'b0;
			end else begin
				e.x = quotient(h[0], h[3], cl);
				e.y = quotient(h[1], h[3], cl);
				e.z = quotient(h[2], h[3], cl);
				e.wz = 1'b0;
				e.cl = cl;
			end
			pending.push_back(e);
		endfunction

		function void check_result(ndc_t a);
			ndc_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h z=%h", $time, a.x, a.y, a.z);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (a.x !== e.x) begin
				$display("%0t: ndc_x expected %h actual %h", $time, e.x, a.x);
				errors++;
			end
			if (a.y !== e.y) begin
				$display("%0t: ndc_y expected %h actual %h", $time, e.y, a.y);
				errors++;
			end
			if (a.z !== e.z) begin
				$display("%0t: ndc_z expected %h actual %h", $time, e.z, a.z);
				errors++;
			end
			if (a.wz !== e.wz) begin
				$display("%0t: w_was_zero expected %b actual %b", $time, e.wz, a.wz);
				errors++;
			end
			if (a.cl !== e.cl) begin
				$display("%0t: clamped expected %b actual %b", $time, e.cl, a.cl);
				errors++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic signed [31:0]   pos_x;
	logic signed [31:0]   pos_y;
	logic signed [31:0]   pos_z;
	logic                 out_valid;
	logic                 out_stall;
	logic signed [31:0]   ndc_x;
	logic signed [31:0]   ndc_y;
	logic signed [31:0]   ndc_z;
	logic                 w_was_zero;
	logic                 clamped;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	ndc_scoreboard sb = new();
	bit            calm;
	int            hold_off;
	logic [31:0]   w_offset;

	vertex_transform_perspective_divide_core DUT (.*);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		sb.write_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_matrix(logic [CFG_W-1:0] m [MAT_REGS]);
		for (int i = 0; i < MAT_REGS; i++) begin
			write_cfg(CFG_IDX_W'(i), m[i]);
		end
	endtask

	task automatic send_vertex(logic signed [31:0] px, logic signed [31:0] py,
			logic signed [31:0] pz);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		do @(negedge clk); while (in_stall);
		sb.note_vertex(px, py, pz);
		@(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (NUM_STAGES + 4) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		int sel;
		sel = $urandom_range(0, 3);
		if (mode == 1 && sel == 0) begin
			return -w_offset;
		end
		if (sel == 1) begin
			return $urandom;
		end
		return 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
	endfunction

	function automatic logic [31:0] small_entry();
		return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
	endfunction

	always begin
		int gap;
		@(posedge clk);
		if (arst_n) begin
			if (hold_off > 0) begin
				out_stall <= 1'b1;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
			end else begin
				gap = calm ? 0 : $urandom_range(0, 5);
				if (gap > 0) begin
					out_stall <= 1'b1;
					repeat (gap) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			do @(negedge clk); while (!out_valid);
			sb.check_result('{ndc_x, ndc_y, ndc_z, w_was_zero, clamped});
		end
	end

	initial begin
		logic [CFG_W-1:0]   m [MAT_REGS];
		logic signed [31:0] d [12];
		int                 mode;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		hold_off = 0;
		w_offset = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		d = '{32'sh0, 32'sh7FFF_FFFF, -32'sh8000_0000, 32'sh1_0000, -32'sh1_0000, 32'sh1,
			-32'sh1, 32'sh0000_8000, 32'sh5555_5555, -32'sh2AAA_AAAB, 32'sh00FF_0000, 32'sh3};
		for (int i = 0; i < 12; i++) begin
			send_vertex(d[i], d[(i + 1) % 12], d[(i + 5) % 12]);
		end
		drain();

		for (int ph = 0; ph < 9; ph++) begin
			mode = 0;
			case (ph)
				0: begin
					write_cfg(CFG_IDX_W'(MAT_REGS), {$urandom, $urandom});
					write_cfg(MAT_REG_LAST + 8'd9, {$urandom, $urandom});
					write_cfg({CFG_IDX_W{1'b1}}, {$urandom, $urandom});
				end
				1: begin
					for (int i = 0; i < MAT_REGS; i++) m[i] = {$urandom, $urandom};
					load_matrix(m);
				end
				2, 3: begin
					mode = 1;
					w_offset = small_entry();
					for (int i = 0; i < MAT_REGS; i++) m[i] = {small_entry(), small_entry()};
					m[6] = '0;
					m[7] = {w_offset, 32'h0001_0000};
					load_matrix(m);
				end
				4: begin
					for (int i = 0; i < MAT_REGS; i++) m[i] = {CFG_W{1'b1}};
					load_matrix(m);
				end
				5: begin
					for (int i = 0; i < MAT_REGS; i++) m[i] = 64'h8000_0000_8000_0000;
					load_matrix(m);
				end
				6: begin
					for (int i = 0; i < MAT_REGS; i++) m[i] = 64'h7FFF_FFFF_7FFF_FFFF;
					load_matrix(m);
				end
				7: begin
					for (int i = 0; i < MAT_REGS; i++) m[i] = '0;
					load_matrix(m);
				end
				default: begin
					for (int i = 0; i < MAT_REGS; i++) m[i] = {small_entry(), small_entry()};
					m[7][63:32] = 32'h0001_0000;
					load_matrix(m);
				end
			endcase
			calm = (ph % 3 == 2);
			if (ph == 3) hold_off = 300;
			for (int n = 0; n < 150; n++) begin
				send_vertex(rand_coord(0), rand_coord(0), rand_coord(mode));
			end
			calm = 1'b0;
			drain();
		end

		if (sb.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
